// ===== rtl/pid_pkg.sv =====
// Shared types, constants and random-draw helpers for the packet impairment decider.
`timescale 1ns / 1ps
package pid_pkg;

  localparam int unsigned PctW    = 7;
  localparam int unsigned OffsetW = 14;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned GenW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PosSumW = 25;  // corrupt offset plus a 24-bit position draw

  localparam logic [GenW-1:0]    SeedReset  = 32'h5555_5555;
  localparam logic [PctW-1:0]    PctRange   = 7'd100;
  localparam logic [WidthW-1:0]  WidthReset = 16'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_REORDER_PCT    = 3'd0,
    REG_CORRUPT_PCT    = 3'd1,
    REG_CORRUPT_OFFSET = 3'd2,
    REG_CORRUPT_WIDTH  = 3'd3,
    REG_RANDOM_SEED    = 3'd4
  } cfg_reg_e;

  // Settings the draw unit needs
  typedef struct packed {
    logic [PctW-1:0]   reorder_pct;
    logic [PctW-1:0]   corrupt_pct;
    logic [WidthW-1:0] corrupt_width;
  } rng_cfg_t;

  // Candidate draws for one item; state[j] is the generator after j+1 steps
  typedef struct packed {
    logic [3:0][GenW-1:0] state;
    logic                 reorder_hit;
    logic [2:0]           corrupt_hit;
    logic [2:0][GenW-1:0] corrupt_rnd;
  } rng_t;

  // One xorshift32 step (13, 17, 5)
  function automatic logic [GenW-1:0] xorshift32(input logic [GenW-1:0] x);
    logic [GenW-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // floor(x * 100 / 2^32)
  function automatic logic [PctW-1:0] draw_pct(input logic [GenW-1:0] x);
    logic [GenW+PctW-1:0] p;
    p = {{PctW{1'b0}}, x} * {{GenW{1'b0}}, PctRange};
    return p[GenW +: PctW];
  endfunction

endpackage

// ===== rtl/pid_rng.sv =====
// Generator chain and parallel candidate draws for one item.
`timescale 1ns / 1ps
module pid_rng (
  input  logic [pid_pkg::GenW-1:0] gen_i,
  input  pid_pkg::rng_cfg_t        cfg_i,
  output pid_pkg::rng_t            rng_o
);

  localparam int unsigned ProdW = pid_pkg::GenW + pid_pkg::WidthW;

  logic [3:0][pid_pkg::GenW-1:0] st;
  logic [2:0][ProdW-1:0]         wprod;

  // Four chained generator steps, enough for the longest item
  always_comb begin
    st[0] = pid_pkg::xorshift32(gen_i);
    st[1] = pid_pkg::xorshift32(st[0]);
    st[2] = pid_pkg::xorshift32(st[1]);
    st[3] = pid_pkg::xorshift32(st[2]);
  end

  // Percent checks and position draws for every place they may fall
  always_comb begin
    rng_o.state       = st;
    rng_o.reorder_hit = pid_pkg::draw_pct(st[0]) < cfg_i.reorder_pct;
    for (int j = 0; j < 3; j++) begin
      rng_o.corrupt_hit[j] = pid_pkg::draw_pct(st[j]) < cfg_i.corrupt_pct;
      wprod[j] = {{pid_pkg::WidthW{1'b0}}, st[j+1]} *
                 {{pid_pkg::GenW{1'b0}}, cfg_i.corrupt_width};
      // range is width*256; a zero width wraps to 2^32 and yields the whole word
      if (cfg_i.corrupt_width == '0) begin
        rng_o.corrupt_rnd[j] = st[j+1];
      end else begin
        rng_o.corrupt_rnd[j] = {8'd0, wprod[j][24 +: 24]};
      end
    end
  end

endmodule

// ===== rtl/packet_impairment_decider_top.sv =====
// Top level: input register, single-pass impairment decision, result register.
// Stages: input register, then result register; a result stall holds an item in the input
//   register until the result register can take it.
// Throughput: one item per cycle while out_stall_i stays low; the generator chain, ring read
//   and draw products all settle between the input register and the result register.
// Reset (rst_ni low, asynchronous): pipeline empty, generator 0x55555555, ring
//   pointer 0, all stored slot lengths 0, configuration registers at their reset values.
`timescale 1ns / 1ps
module packet_impairment_decider_top #(
  parameter int unsigned RING_DEPTH       = 20,
  parameter int unsigned MAX_PACKET_BYTES = 16384,
  localparam int unsigned SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned LEN_W  = $clog2(MAX_PACKET_BYTES + 1),
  localparam int unsigned POS_W  = $clog2(MAX_PACKET_BYTES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pid_pkg::GenW-1:0]     cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [LEN_W-1:0]             received_length_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         store_enable_o,
  output logic [SLOT_W-1:0]            store_slot_o,
  output logic                         forward_o,
  output logic [SLOT_W-1:0]            read_slot_o,
  output logic [LEN_W-1:0]             send_length_o,
  output logic                         corrupt_o,
  output logic [POS_W-1:0]             corrupt_position_o,
  output logic [7:0]                   corrupt_mask_o
);

  localparam int unsigned MW = $clog2(RING_DEPTH + 2);  // holds RING_DEPTH+1
  localparam logic [MW-1:0]     RingRange = MW'(RING_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LastSlot  = SLOT_W'(RING_DEPTH - 1);
  localparam logic [LEN_W-1:0]  MaxLen    = LEN_W'(MAX_PACKET_BYTES);

  // configuration registers
  logic [pid_pkg::PctW-1:0]    reorder_pct_q, corrupt_pct_q;
  logic [pid_pkg::OffsetW-1:0] corrupt_offset_q;
  logic [pid_pkg::WidthW-1:0]  corrupt_width_q;

  // block state
  logic [pid_pkg::GenW-1:0] gen_q, gen_d;
  logic [SLOT_W-1:0]        ptr_q, ptr_d;
  logic [LEN_W-1:0]         ring_q [RING_DEPTH];

  // pipeline registers
  logic             s1_valid_q;
  logic [LEN_W-1:0] s1_len_q;
  logic             out_valid_q;
  logic             in_fire, out_load, cfg_fire;

  // decision signals
  pid_pkg::rng_cfg_t      rng_cfg;
  pid_pkg::rng_t          rng;
  logic [LEN_W-1:0]       rx, len;
  logic                   reorder_on, dropped, fwd, corr;
  logic [SLOT_W-1:0]      rd_slot, idx;
  logic [pid_pkg::GenW+MW-1:0] kprod;
  logic [MW-1:0]          k, km1;
  logic [2:0]             used, um1;
  logic [1:0]             sel;
  logic [pid_pkg::GenW-1:0]    rnd;
  logic [pid_pkg::PosSumW-1:0] pos;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign out_load    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & ~out_load;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reorder_pct_q    <= '0;
      corrupt_pct_q    <= '0;
      corrupt_offset_q <= '0;
      corrupt_width_q  <= pid_pkg::WidthReset;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        pid_pkg::REG_REORDER_PCT:    reorder_pct_q    <= cfg_data_i[pid_pkg::PctW-1:0];
        pid_pkg::REG_CORRUPT_PCT:    corrupt_pct_q    <= cfg_data_i[pid_pkg::PctW-1:0];
        pid_pkg::REG_CORRUPT_OFFSET: corrupt_offset_q <= cfg_data_i[pid_pkg::OffsetW-1:0];
        pid_pkg::REG_CORRUPT_WIDTH:  corrupt_width_q  <= cfg_data_i[pid_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // draw unit
  assign rng_cfg = '{reorder_pct: reorder_pct_q, corrupt_pct: corrupt_pct_q,
                     corrupt_width: corrupt_width_q};

  pid_rng u_rng (
    .gen_i (gen_q),
    .cfg_i (rng_cfg),
    .rng_o (rng)
  );

  // ring slot draw uses the second generator step
  assign kprod = {{MW{1'b0}}, rng.state[1]} * {{pid_pkg::GenW{1'b0}}, RingRange};
  assign k     = kprod[pid_pkg::GenW +: MW];
  assign km1   = k - MW'(1);
  assign idx   = SLOT_W'(km1);

  // single-pass decision for the item in the input register
  always_comb begin
    rx         = (s1_len_q > MaxLen) ? MaxLen : s1_len_q;
    reorder_on = reorder_pct_q != '0;
    ptr_d      = (ptr_q == LastSlot) ? '0 : ptr_q + SLOT_W'(1);
    len        = rx;
    // with the ring off the read slot stays at zero
    rd_slot    = reorder_on ? ptr_d : '0;
    dropped    = 1'b0;
    used       = 3'd0;
    rnd        = '0;
    corr       = 1'b0;

    if (reorder_on) begin
      used = 3'd1;
      if (rng.reorder_hit) begin
        used = 3'd2;
        if (k == '0) begin
          dropped = 1'b1;
        end else begin
          rd_slot = idx;
          // the slot being written this cycle reads back the new length
          len = (idx == ptr_d) ? rx : ring_q[idx];
        end
      end
    end

    fwd = ~dropped & (len != '0);
    sel = used[1:0];
    if (fwd && corrupt_pct_q != '0) begin
      if (rng.corrupt_hit[sel]) begin
        rnd  = rng.corrupt_rnd[sel];
        used = used + 3'd2;
      end else begin
        used = used + 3'd1;
      end
    end

    pos = pid_pkg::PosSumW'(corrupt_offset_q) + pid_pkg::PosSumW'(rnd[31:8]);
    if (fwd && used > {1'b0, sel} + 3'd1) begin
      corr = pos < pid_pkg::PosSumW'(len);
    end

    um1   = used - 3'd1;
    gen_d = (used == 3'd0) ? gen_q : rng.state[um1[1:0]];
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_len_q <= received_length_i;
    end
  end

  // generator, ring pointer and slot lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= pid_pkg::SeedReset;
      ptr_q <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (cfg_fire && cfg_index_i == pid_pkg::REG_RANDOM_SEED) begin
        gen_q <= cfg_data_i;
      end else if (out_load) begin
        gen_q <= gen_d;
      end
      if (out_load && reorder_on) begin
        ptr_q         <= ptr_d;
        ring_q[ptr_d] <= rx;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      store_enable_o     <= reorder_on;
      store_slot_o       <= reorder_on ? ptr_d : '0;
      forward_o          <= fwd;
      read_slot_o        <= fwd ? rd_slot : '0;
      send_length_o      <= fwd ? len : '0;
      corrupt_o          <= corr;
      corrupt_position_o <= corr ? POS_W'(pos) : '0;
      corrupt_mask_o     <= corr ? rnd[7:0] : '0;
    end
  end

endmodule
